// File: hdl/serial_actuator_command_parser_macros.svh
// Assertion macros shared by the command parser RTL.
`ifndef SERIAL_ACTUATOR_COMMAND_PARSER_MACROS_SVH
`define SERIAL_ACTUATOR_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SCP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SCP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/scp_pkg.sv
// Shared types, codes and keyword table of the command parser.
package scp_pkg;

   localparam int LINE_BUFFER_BYTES_DEF = 64;
   localparam int KW_MAX = 9;
   localparam int KW_NUM = 14;

   localparam logic [7:0] KEY_DEL = 8'h7F;
   localparam logic [7:0] KEY_BS = 8'h08;
   localparam logic [7:0] KEY_CR = 8'h0D;
   localparam logic [7:0] KEY_LF = 8'h0A;
   localparam logic [7:0] KEY_SPACE = 8'h20;

   typedef logic [2:0] action_type;
   localparam action_type ACT_BIN_ON = 3'd0;
   localparam action_type ACT_BIN_OFF = 3'd1;
   localparam action_type ACT_MOTOR = 3'd2;
   localparam action_type ACT_STATUS = 3'd3;
   localparam action_type ACT_ALERT = 3'd4;
   localparam action_type ACT_INVALID = 3'd5;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_MOTOR_MIN = 2'd0;
   localparam csr_index_type CSR_MOTOR_MAX = 2'd1;
   localparam csr_index_type CSR_IDLE_TICKS = 2'd2;

   localparam logic signed [10:0] MOTOR_MIN_RST = -11'sd100;
   localparam logic signed [10:0] MOTOR_MAX_RST = 11'sd100;
   localparam logic [15:0] IDLE_TICKS_RST = 16'd1000;

   typedef logic [7:0] char_type;
   typedef char_type [KW_MAX-1:0] kwbuf_type;

   // keyword text, right-justified: the last character sits in the low byte
   localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_NUM] = '{
      72'("BIN ON"), 72'("BINON"), 72'("ON"), 72'("RELAY ON"), 72'("RELAYON"),
      72'("BIN OFF"), 72'("BINOFF"), 72'("OFF"), 72'("RELAY OFF"), 72'("RELAYOFF"),
      72'("STOP"), 72'("MOTOR 0"), 72'("STATUS"), 72'("ALERT")};
   localparam int KW_LEN [KW_NUM] = '{6, 5, 2, 8, 7, 7, 6, 3, 9, 8, 4, 7, 6, 5};
   localparam action_type KW_ACT [KW_NUM] = '{
      ACT_BIN_ON, ACT_BIN_ON, ACT_BIN_ON, ACT_BIN_ON, ACT_BIN_ON,
      ACT_BIN_OFF, ACT_BIN_OFF, ACT_BIN_OFF, ACT_BIN_OFF, ACT_BIN_OFF,
      ACT_MOTOR, ACT_MOTOR, ACT_STATUS, ACT_ALERT};
   localparam logic KW_IMM [KW_NUM] = '{
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b1, 1'b0, 1'b1, 1'b1};

   typedef struct packed {
      logic hit;
      logic imm;
      action_type action;
   } kw_hit_type;

   // Exact match of the first len characters against the keyword table.
   // A len above KW_MAX never matches.
   function automatic kw_hit_type kw_lookup(input kwbuf_type text, input logic [3:0] len);
      kw_hit_type res;
      logic eq;
      res = '0;
      for (int k = 0; k < KW_NUM; k++) begin
         eq = (len == 4'(KW_LEN[k]));
         for (int j = 0; j < KW_MAX; j++) begin
            if (j < KW_LEN[k]) begin
               if (text[j] != KW_TEXT[k][8*(KW_LEN[k]-1-j) +: 8]) begin
                  eq = 1'b0;
               end
            end
         end
         if (eq) begin
            res.hit = 1'b1;
            res.imm = KW_IMM[k];
            res.action = KW_ACT[k];
         end
      end
      return res;
   endfunction

   typedef struct packed {
      logic take;
      logic scan_init;
      logic scan_en;
      logic load_out;
   } scp_cmd_type;

   typedef struct packed {
      logic commit_now;
      logic appended;
      logic immediate;
      logic scan_done;
      logic line_empty;
   } scp_status_type;

endpackage

// File: hdl/scp_req_if.sv
// Request channel: serial byte or millisecond tick.
interface scp_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic [7:0] rx_byte;
   modport source (output valid, req_type, rx_byte, input ready);
   modport sink (input valid, req_type, rx_byte, output ready);
endinterface

// File: hdl/scp_rsp_if.sv
// Result channel: decoded command action.
interface scp_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] action;
   logic signed [31:0] motor_target;
   logic limited;
   logic [31:0] event_time_ms;
   modport source (output valid, action, motor_target, limited, event_time_ms, input ready);
   modport sink (input valid, action, motor_target, limited, event_time_ms, output ready);
endinterface

// File: hdl/scp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 63
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: hdl/scp_datapath.sv
// Line buffer, timers, config registers, line scanner and result register.
module scp_datapath import scp_pkg::*; #(
   parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                req_type,
   input  logic [7:0]          rx_byte,
   input  scp_cmd_type         cmd,
   output scp_status_type      status,
   output action_type          out_action,
   output logic signed [31:0]  out_target,
   output logic                out_limited,
   output logic [31:0]         out_time
);
   localparam int LINE_CAP = LINE_BUFFER_BYTES - 1;
   localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
   localparam int ADDR_W = $clog2(LINE_CAP);

   // number parser states
   localparam logic [3:0] P_LEAD = 4'd0;
   localparam logic [3:0] P_AFTER_M = 4'd1;
   localparam logic [3:0] P_MO = 4'd2;
   localparam logic [3:0] P_MOT = 4'd3;
   localparam logic [3:0] P_MOTO = 4'd4;
   localparam logic [3:0] P_SP = 4'd5;
   localparam logic [3:0] P_SIGN = 4'd6;
   localparam logic [3:0] P_DIG = 4'd7;
   localparam logic [3:0] P_TRAIL = 4'd8;
   localparam logic [3:0] P_BAD = 4'd9;

   logic signed [10:0] min_ff, min_in, max_ff, max_in;
   logic [15:0] ticks_ff, ticks_in, idle_ff, idle_in, idle_inc;
   logic [31:0] time_ff, time_in;
   logic [LEN_W-1:0] len_ff, len_in;
   kwbuf_type shadow_ff, shadow_in;

   logic [LEN_W-1:0] snap_ff, snap_in, rd_ptr_ff, rd_ptr_in, rel_ff, rel_in, tlen_ff, tlen_in;
   logic dvalid_ff, dvalid_in, seen_ff, seen_in, neg_ff, neg_in;
   logic [3:0] ps_ff, ps_in;
   logic [31:0] mag_ff, mag_in;
   kwbuf_type kbuf_ff, kbuf_in;

   action_type act_ff, act_in;
   logic signed [31:0] tgt_ff, tgt_in;
   logic lim_ff, lim_in;
   logic [31:0] otime_ff;

   logic is_eol, is_del, printable, has_room;
   logic [7:0] upper;
   logic ram_we;
   logic [ADDR_W-1:0] raddr;
   logic [7:0] rdata;
   logic c_sp, c_dig, c_sign;
   logic [35:0] acc;
   kw_hit_type imm_hit, fin_hit;
   logic signed [31:0] value;
   logic signed [31:0] min_ext, max_ext;

   scp_ram #(.WIDTH(8), .DEPTH(LINE_CAP)) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (len_ff[ADDR_W-1:0]),
      .wdata (upper),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      is_eol = rx_byte inside {KEY_LF, KEY_CR};
      is_del = rx_byte inside {KEY_BS, KEY_DEL};
      printable = (rx_byte >= KEY_SPACE) && (rx_byte < KEY_DEL);
      upper = (rx_byte >= 8'h61 && rx_byte <= 8'h7A) ? rx_byte - 8'h20 : rx_byte;
      has_room = len_ff < LEN_W'(LINE_CAP);
      idle_inc = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      status.commit_now = req_type ? ((len_ff != '0) && (idle_inc >= ticks_ff))
                                   : (is_eol && (len_ff != '0));
      status.appended = !req_type && printable && has_room;
      imm_hit = kw_lookup(shadow_ff,
                          (len_ff <= LEN_W'(KW_MAX)) ? 4'(len_ff) : 4'd15);
      status.immediate = imm_hit.hit && imm_hit.imm;
      status.scan_done = (rd_ptr_ff == snap_ff) && !dvalid_ff;
      status.line_empty = !seen_ff;
      ram_we = cmd.take && status.appended;
   end

   // config, timers, line
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      ticks_in = ticks_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MOTOR_MIN: min_in = csr_wdata[10:0];
            CSR_MOTOR_MAX: max_in = csr_wdata[10:0];
            CSR_IDLE_TICKS: ticks_in = csr_wdata;
            default: ;
         endcase
      end
      time_in = time_ff;
      idle_in = idle_ff;
      len_in = len_ff;
      shadow_in = shadow_ff;
      if (cmd.take) begin
         if (req_type) begin
            time_in = time_ff + 32'd1;
            idle_in = idle_inc;
         end else begin
            idle_in = '0;
            if (is_del && len_ff != '0) begin
               len_in = len_ff - LEN_W'(1);
            end else if (status.appended) begin
               len_in = len_ff + LEN_W'(1);
               for (int i = 0; i < KW_MAX; i++) begin
                  if (len_ff == LEN_W'(i)) begin
                     shadow_in[i] = upper;
                  end
               end
            end
         end
      end
      if (cmd.scan_init) begin
         len_in = '0;
      end
   end

   // line scan: one character a cycle from the RAM
   always_comb begin
      snap_in = snap_ff;
      rd_ptr_in = rd_ptr_ff;
      dvalid_in = 1'b0;
      rel_in = rel_ff;
      tlen_in = tlen_ff;
      seen_in = seen_ff;
      neg_in = neg_ff;
      ps_in = ps_ff;
      mag_in = mag_ff;
      kbuf_in = kbuf_ff;
      raddr = rd_ptr_ff[ADDR_W-1:0];
      c_sp = rdata == KEY_SPACE;
      c_dig = rdata >= 8'h30 && rdata <= 8'h39;
      c_sign = rdata inside {8'h2B, 8'h2D};
      acc = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0} + {32'd0, rdata[3:0]};
      if (cmd.scan_init) begin
         snap_in = len_ff;
         rd_ptr_in = '0;
         rel_in = '0;
         tlen_in = '0;
         seen_in = 1'b0;
         neg_in = 1'b0;
         ps_in = P_LEAD;
         mag_in = '0;
      end else if (cmd.scan_en) begin
         if (rd_ptr_ff != snap_ff) begin
            rd_ptr_in = rd_ptr_ff + LEN_W'(1);
            dvalid_in = 1'b1;
         end
         if (dvalid_ff) begin
            if (seen_ff || !c_sp) begin
               seen_in = 1'b1;
               for (int i = 0; i < KW_MAX; i++) begin
                  if (rel_ff == LEN_W'(i)) begin
                     kbuf_in[i] = rdata;
                  end
               end
               rel_in = rel_ff + LEN_W'(1);
               if (!c_sp) begin
                  tlen_in = rel_ff + LEN_W'(1);
               end
            end
            case (ps_ff)
               P_LEAD: ps_in = c_sp ? P_LEAD : (rdata == 8'h4D ? P_AFTER_M : P_BAD);
               P_AFTER_M, P_SP: begin
                  if (ps_ff == P_AFTER_M && rdata == 8'h4F) begin
                     ps_in = P_MO;
                  end else if (c_sp) begin
                     ps_in = P_SP;
                  end else if (c_sign) begin
                     ps_in = P_SIGN;
                     neg_in = rdata == 8'h2D;
                  end else if (c_dig) begin
                     ps_in = P_DIG;
                     mag_in = 32'(acc);
                  end else begin
                     ps_in = P_BAD;
                  end
               end
               P_MO: ps_in = (rdata == 8'h54) ? P_MOT : P_BAD;
               P_MOT: ps_in = (rdata == 8'h4F) ? P_MOTO : P_BAD;
               P_MOTO: ps_in = (rdata == 8'h52) ? P_SP : P_BAD;
               P_SIGN, P_DIG: begin
                  if (c_dig) begin
                     ps_in = P_DIG;
                     mag_in = (acc > 36'h080000000) ? 32'h80000000 : acc[31:0];
                  end else if (c_sp && ps_ff == P_DIG) begin
                     ps_in = P_TRAIL;
                  end else begin
                     ps_in = P_BAD;
                  end
               end
               P_TRAIL: ps_in = c_sp ? P_TRAIL : P_BAD;
               default: ps_in = P_BAD;
            endcase
         end
      end
   end

   // decode of the scanned line
   always_comb begin
      fin_hit = kw_lookup(kbuf_ff, (tlen_ff <= LEN_W'(KW_MAX)) ? 4'(tlen_ff) : 4'd15);
      min_ext = 32'(min_ff);
      max_ext = 32'(max_ff);
      if (neg_ff) begin
         value = -$signed(mag_ff);
      end else begin
         value = mag_ff[31] ? 32'sh7FFFFFFF : $signed(mag_ff);
      end
      act_in = ACT_INVALID;
      tgt_in = '0;
      lim_in = 1'b0;
      if (fin_hit.hit) begin
         act_in = fin_hit.action;
      end else if (ps_ff == P_DIG || ps_ff == P_TRAIL) begin
         act_in = ACT_MOTOR;
         tgt_in = value;
         lim_in = (value < min_ext) || (value > max_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MOTOR_MIN_RST;
         max_ff <= MOTOR_MAX_RST;
         ticks_ff <= IDLE_TICKS_RST;
         time_ff <= '0;
         idle_ff <= '0;
         len_ff <= '0;
         snap_ff <= '0;
         rd_ptr_ff <= '0;
         dvalid_ff <= 1'b0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
         ticks_ff <= ticks_in;
         time_ff <= time_in;
         idle_ff <= idle_in;
         len_ff <= len_in;
         snap_ff <= snap_in;
         rd_ptr_ff <= rd_ptr_in;
         dvalid_ff <= dvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      shadow_ff <= shadow_in;
      rel_ff <= rel_in;
      tlen_ff <= tlen_in;
      seen_ff <= seen_in;
      neg_ff <= neg_in;
      ps_ff <= ps_in;
      mag_ff <= mag_in;
      kbuf_ff <= kbuf_in;
      if (cmd.load_out) begin
         act_ff <= act_in;
         tgt_ff <= tgt_in;
         lim_ff <= lim_in;
         otime_ff <= time_ff;
      end
   end

   assign out_action = act_ff;
   assign out_target = tgt_ff;
   assign out_limited = lim_ff;
   assign out_time = otime_ff;
endmodule

// File: hdl/scp_ctrl.sv
// Controller: request intake, commit sequencing and result valid.
module scp_ctrl import scp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  scp_status_type status,
   output scp_cmd_type    cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      out_free = !rsp_valid_ff || rsp_ready;
      req_ready = state_ff == ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.commit_now) begin
                  cmd.scan_init = 1'b1;
                  state_in = ST_SCAN;
               end else if (status.appended) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (status.immediate) begin
               cmd.scan_init = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.line_empty) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// File: hdl/serial_actuator_command_parser.sv
// A byte or tick that commits nothing is taken in ST_IDLE; an appended byte passes ST_CHECK too.
// A commit walks the stored line through the line RAM, one character a cycle, in ST_SCAN;
// ST_FINISH then loads the result register, unless the line was empty, once it is free.
// Requests are handled one at a time; none is taken during the line walk.
// Reset (synchronous): empties the line, clears time and idle counters, loads
// default limits and idle timeout; line RAM contents are left as they are.
module serial_actuator_command_parser import scp_pkg::*; #(
   parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   scp_req_if.sink       req_chan,
   scp_rsp_if.source     rsp_chan,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);
   `include "serial_actuator_command_parser_macros.svh"

   // control <-> datapath
   scp_cmd_type cmd;
   scp_status_type status;

   // controller: sequences intake, the line walk and the output register
   scp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: line RAM, timers, number parser, keyword match
   scp_datapath #(.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_type    (req_chan.req_type),
      .rx_byte     (req_chan.rx_byte),
      .cmd         (cmd),
      .status      (status),
      .out_action  (rsp_chan.action),
      .out_target  (rsp_chan.motor_target),
      .out_limited (rsp_chan.limited),
      .out_time    (rsp_chan.event_time_ms)
   );

   // a result is only loaded when the output register is free
   `SCP_ASSERT_NOW(a_load_free, cmd.load_out, !rsp_chan.valid || rsp_chan.ready, "result overwritten")
   // once a line walk starts, no request is taken
   `SCP_ASSERT_NEXT(a_busy_walk, cmd.scan_init, !req_chan.ready, "request taken during line walk")
   // only motor results carry a target or limited flag
   `SCP_ASSERT_NOW(a_tgt_zero, rsp_chan.valid && rsp_chan.action != ACT_MOTOR, rsp_chan.motor_target == 0 && !rsp_chan.limited, "target on non-motor action")
endmodule
